/* sv/gba_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gba_pkg
// Shared types, widths and codes of the grouped bitmap allocator.
// ---------------------------------------------------------------------------
package gba_pkg;

    // default sizes of the map, the group count store and one load word
    localparam int unsigned MAP_BITS_DEF       = 4096;
    localparam int unsigned MAX_GROUPS_DEF     = 8;
    localparam int unsigned LOAD_WORD_BITS_DEF = 32;

    // field widths
    localparam int unsigned CNT_W   = 13;
    localparam int unsigned SLOT_W  = 7;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned OGRP_W  = 3;
    // map bit positions, wide enough for one group end past the total
    localparam int unsigned POS_W   = 15;

    // configuration port
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_ALLOC      = 2'd0,
        CMD_LOAD_WORD  = 2'd1,
        CMD_LOAD_GROUP = 2'd2,
        CMD_LOAD_TOTAL = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_ITEMS_PER_GROUP = 2'd0,
        REG_TOTAL_ITEMS     = 2'd1,
        REG_FIRST_USABLE    = 2'd2,
        REG_NUMBER_BASE     = 2'd3
    } t_reg;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_NO_FREE = 1'b1;

endpackage

/* sv/grouped_bitmap_allocator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grouped_bitmap_allocator
// First-fit allocator over a grouped used-bit map held in one memory.
// ---------------------------------------------------------------------------
// Load commands answer with status done. An allocate visits the groups in
// order, steps through the map words of each group it scans and then leaves
// that group; the map memory has a single read port and one word is examined
// per cycle while scanning, unless a hit waits for the output register. The
// found bit is set by a read-modify-write of that word, and the group and
// total free counts drop by one, saturating at zero. A new command is taken
// while the previous result still waits on the master side, except that a
// load then waits for the output register to free up. Configuration must be
// written over the APB port only while no command is in progress; the block
// itself does not enforce this.
module grouped_bitmap_allocator
    import gba_pkg::*;
#(
    parameter int unsigned MAP_BITS       = MAP_BITS_DEF,
    parameter int unsigned MAX_GROUPS     = MAX_GROUPS_DEF,
    parameter int unsigned LOAD_WORD_BITS = LOAD_WORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [6:0] slot, [38:7] value, [39] zero
    input  logic [39:0]         s_axis_tdata,
    // [1:0] command
    input  logic [CMD_W-1:0]    s_axis_tuser,

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [12:0] allocated_number, [15:13] allocated_group
    output logic [15:0]         m_axis_tdata,
    // [0] status
    output logic                m_axis_tuser
);

    localparam int unsigned MAP_WORDS = MAP_BITS / LOAD_WORD_BITS;
    localparam int unsigned WIDX      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned OFF_W     = $clog2(LOAD_WORD_BITS + 1);
    localparam int unsigned GIW       = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int unsigned GW        = GIW + 1;
    localparam int unsigned MAP_CAP   = (MAP_BITS > 16383) ? 16383 : MAP_BITS;
    localparam int unsigned LW        = LOAD_WORD_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GROUP,
        S_SCAN
    } t_state;

    t_state              r_state, n_state;

    logic [CNT_W-1:0]    r_ipg, n_ipg;
    logic [CNT_W-1:0]    r_total, n_total;
    logic [CNT_W-1:0]    r_fu, n_fu;
    logic                r_base, n_base;

    logic [GW-1:0]       r_grp, n_grp;
    logic [POS_W-1:0]    r_start, n_start;
    logic [POS_W-1:0]    r_lo, n_lo;
    logic [POS_W-1:0]    r_hi, n_hi;
    logic [WIDX-1:0]     r_word, n_word;
    logic [POS_W-1:0]    r_wbase, n_wbase;

    logic [CNT_W-1:0]    r_gfree [MAX_GROUPS];
    logic [CNT_W-1:0]    n_gfree [MAX_GROUPS];
    logic [CNT_W-1:0]    r_tfree, n_tfree;

    logic [MAP_WORDS-1:0] r_wvalid, n_wvalid;

    logic                r_out_valid, n_out_valid;
    logic                r_out_status, n_out_status;
    logic [CNT_W-1:0]    r_out_num, n_out_num;
    logic [OGRP_W-1:0]   r_out_grp, n_out_grp;

    // map memory
    logic [LW-1:0]       r_mem [MAP_WORDS];
    logic [LW-1:0]       r_rdata;
    logic                r_rvalid;
    logic                wr_en;
    logic [WIDX-1:0]     wr_addr;
    logic [LW-1:0]       wr_data;

    logic                cfg_wr;
    logic [SLOT_W-1:0]   in_slot;
    logic [VALUE_W-1:0]  in_value;
    t_cmd                in_cmd;
    logic                in_xfer;
    logic                out_free;

    logic [POS_W-1:0]    fu_adj;
    logic [POS_W-1:0]    grp_end;
    logic [POS_W-1:0]    total_ext;
    logic [POS_W-1:0]    grp_lo;
    logic [POS_W-1:0]    grp_hi;
    logic [CNT_W-1:0]    gfree_cur;
    logic [GIW-1:0]      gidx;

    logic [POS_W-1:0]    wend;
    logic [OFF_W-1:0]    lo_off;
    logic [OFF_W-1:0]    hi_off;
    logic [LW-1:0]       word;
    logic [LW-1:0]       mask;
    logic [LW-1:0]       cand;
    logic [OFF_W-1:0]    pos;
    logic                found;
    logic [POS_W-1:0]    hit_idx;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    assign in_slot  = s_axis_tdata[SLOT_W-1:0];
    assign in_value = s_axis_tdata[SLOT_W+VALUE_W-1:SLOT_W];
    assign in_cmd   = t_cmd'(s_axis_tuser);

    assign out_free      = !r_out_valid || m_axis_tready;
    // an allocate may enter while the last result still waits
    assign s_axis_tready = (r_state == S_IDLE) && (out_free || (in_cmd == CMD_ALLOC));
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {r_out_grp, r_out_num};

    always_comb begin
        case (t_reg'(paddr[3:2]))
            REG_ITEMS_PER_GROUP: prdata = DATA_W'(r_ipg);
            REG_TOTAL_ITEMS:     prdata = DATA_W'(r_total);
            REG_FIRST_USABLE:    prdata = DATA_W'(r_fu);
            REG_NUMBER_BASE:     prdata = DATA_W'(r_base);
            default:             prdata = '0;
        endcase
    end

    // group bounds: skip numbers below first_usable, stop at total and map end
    assign gidx      = r_grp[GIW-1:0];
    assign gfree_cur = (r_grp < GW'(MAX_GROUPS)) ? r_gfree[gidx] : '0;
    assign total_ext = POS_W'(r_total);
    assign fu_adj    = (r_base && (r_fu != '0)) ? POS_W'(r_fu - 1'b1) : POS_W'(r_fu);
    assign grp_end   = r_start + POS_W'(r_ipg);

    always_comb begin
        grp_hi = grp_end;
        if (total_ext < grp_hi) begin
            grp_hi = total_ext;
        end
        if (POS_W'(MAP_CAP) < grp_hi) begin
            grp_hi = POS_W'(MAP_CAP);
        end
        grp_lo = (fu_adj > r_start) ? fu_adj : r_start;
    end

    // word scan: range mask within the current word and lowest clear bit
    assign wend   = r_wbase + POS_W'(LW);
    assign lo_off = (r_lo > r_wbase) ? OFF_W'(r_lo - r_wbase) : '0;
    assign hi_off = (r_hi >= wend) ? OFF_W'(LW) : OFF_W'(r_hi - r_wbase);
    assign word   = r_rvalid ? r_rdata : '0;
    assign mask   = ({LW{1'b1}} << lo_off) & ~({LW{1'b1}} << hi_off);
    assign cand   = ~word & mask;
    assign found  = |cand;

    always_comb begin
        pos = '0;
        for (int b = LW - 1; b >= 0; b--) begin
            if (cand[b]) begin
                pos = OFF_W'(b);
            end
        end
    end

    assign hit_idx = r_wbase + POS_W'(pos);

    always_comb begin
        n_state      = r_state;
        n_ipg        = r_ipg;
        n_total      = r_total;
        n_fu         = r_fu;
        n_base       = r_base;
        n_grp        = r_grp;
        n_start      = r_start;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_word       = r_word;
        n_wbase      = r_wbase;
        n_gfree      = r_gfree;
        n_tfree      = r_tfree;
        n_wvalid     = r_wvalid;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_num    = r_out_num;
        n_out_grp    = r_out_grp;
        wr_en        = 1'b0;
        wr_addr      = r_word;
        wr_data      = word | (LW'(1) << pos);

        if (cfg_wr) begin
            case (t_reg'(paddr[3:2]))
                REG_ITEMS_PER_GROUP: n_ipg   = pwdata[CNT_W-1:0];
                REG_TOTAL_ITEMS:     n_total = pwdata[CNT_W-1:0];
                REG_FIRST_USABLE:    n_fu    = pwdata[CNT_W-1:0];
                REG_NUMBER_BASE:     n_base  = pwdata[0];
                default: begin
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (in_cmd == CMD_ALLOC) begin
                        n_grp   = '0;
                        n_start = '0;
                        n_word  = '0;
                        n_wbase = '0;
                        n_state = S_GROUP;
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_status = STATUS_DONE;
                        n_out_num    = '0;
                        n_out_grp    = '0;
                        case (in_cmd)
                            CMD_LOAD_WORD: begin
                                if (32'(in_slot) < MAP_WORDS) begin
                                    wr_en    = 1'b1;
                                    wr_addr  = WIDX'(in_slot);
                                    wr_data  = LW'(in_value);
                                    n_wvalid[WIDX'(in_slot)] = 1'b1;
                                end
                            end
                            CMD_LOAD_GROUP: begin
                                if (32'(in_slot) < MAX_GROUPS) begin
                                    n_gfree[GIW'(in_slot)] = in_value[CNT_W-1:0];
                                end
                            end
                            default: begin
                                n_tfree = in_value[CNT_W-1:0];
                            end
                        endcase
                    end
                end
            end

            S_GROUP: begin
                if ((r_ipg == '0) || (r_grp >= GW'(MAX_GROUPS)) || (r_start >= total_ext)) begin
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_status = STATUS_NO_FREE;
                        n_out_num    = '0;
                        n_out_grp    = '0;
                        n_state      = S_IDLE;
                    end
                end else if ((gfree_cur == '0) || (grp_lo >= grp_hi)) begin
                    n_grp   = r_grp + 1'b1;
                    n_start = grp_end;
                end else begin
                    n_lo    = grp_lo;
                    n_hi    = grp_hi;
                    n_state = S_SCAN;
                end
            end

            S_SCAN: begin
                if (wend <= r_lo) begin
                    n_word  = r_word + 1'b1;
                    n_wbase = wend;
                end else if (found) begin
                    // hold the hit until the output register is free
                    if (out_free) begin
                        wr_en            = 1'b1;
                        n_wvalid[r_word] = 1'b1;
                        if (r_tfree != '0) begin
                            n_tfree = r_tfree - 1'b1;
                        end
                        if (r_gfree[gidx] != '0) begin
                            n_gfree[gidx] = r_gfree[gidx] - 1'b1;
                        end
                        n_out_valid  = 1'b1;
                        n_out_status = STATUS_DONE;
                        n_out_num    = CNT_W'(hit_idx + POS_W'(r_base));
                        n_out_grp    = OGRP_W'(r_grp);
                        n_state      = S_IDLE;
                    end
                end else if (wend >= r_hi) begin
                    n_grp   = r_grp + 1'b1;
                    n_start = grp_end;
                    n_state = S_GROUP;
                end else begin
                    n_word  = r_word + 1'b1;
                    n_wbase = wend;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // map memory: one write port, read address follows the next word pointer
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[n_word];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ipg       <= CNT_W'(4096);
            r_total     <= CNT_W'(4096);
            r_fu        <= '0;
            r_base      <= 1'b0;
            r_tfree     <= '0;
            r_wvalid    <= '0;
            r_rvalid    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int g = 0; g < MAX_GROUPS; g++) begin
                r_gfree[g] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_ipg       <= n_ipg;
            r_total     <= n_total;
            r_fu        <= n_fu;
            r_base      <= n_base;
            r_tfree     <= n_tfree;
            r_wvalid    <= n_wvalid;
            r_rvalid    <= r_wvalid[n_word];
            r_out_valid <= n_out_valid;
            r_gfree     <= n_gfree;
        end
        r_grp        <= n_grp;
        r_start      <= n_start;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_word       <= n_word;
        r_wbase      <= n_wbase;
        r_out_status <= n_out_status;
        r_out_num    <= n_out_num;
        r_out_grp    <= n_out_grp;
    end

endmodule

/* bench/grouped_bitmap_allocator_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grouped_bitmap_allocator_checker
// Watches the command, result and register channels of the allocator, keeps
// its own copy of the used map, the free counts and the settings, works out
// the grant for every accepted command and compares it, field by field, with
// the oldest outstanding grant when a result transfer completes.
// ---------------------------------------------------------------------------
module grouped_bitmap_allocator_checker
    import gba_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [ADDR_W-1:0]   i_paddr,
    input  logic [DATA_W-1:0]   i_pwdata,
    input  logic                i_pready,

    input  logic                i_cmd_tvalid,
    input  logic                i_cmd_tready,
    // [6:0] slot, [38:7] value, [39] zero
    input  logic [39:0]         i_cmd_tdata,
    // [1:0] command
    input  logic [CMD_W-1:0]    i_cmd_tuser,

    input  logic                i_res_tvalid,
    input  logic                i_res_tready,
    // [12:0] allocated_number, [15:13] allocated_group
    input  logic [15:0]         i_res_tdata,
    // [0] status
    input  logic                i_res_tuser,

    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int unsigned MAP_WORDS = MAP_BITS_DEF / LOAD_WORD_BITS_DEF;

    typedef struct packed {
        logic               status;
        logic [CNT_W-1:0]   number;
        logic [OGRP_W-1:0]  group;
    } t_grant;

    logic [LOAD_WORD_BITS_DEF-1:0] used_map [MAP_WORDS];
    logic [CNT_W-1:0]              group_free [MAX_GROUPS_DEF];
    logic [CNT_W-1:0]              total_free;

    logic [CNT_W-1:0] cfg_per_group;
    logic [CNT_W-1:0] cfg_total;
    logic [CNT_W-1:0] cfg_first;
    logic             cfg_base;

    t_grant grants_due [$];
    int     fail_count = 0;
    int     pending_cnt = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;

    task automatic report_mismatch(input string msg);
        if (fail_count < 50) begin
            $display("%0t ns mismatch: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    // first-fit walk over the groups; updates the map and counts on success
    function automatic t_grant grant_for_command(input t_cmd cmd,
                                                 input logic [SLOT_W-1:0] slot,
                                                 input logic [VALUE_W-1:0] value);
        t_grant      grant;
        int unsigned per_group, total, groups, g, k, lim, start, idx, num;
        bit          found;
        grant     = '0;
        found     = 0;
        per_group = 32'(cfg_per_group);
        total     = 32'(cfg_total);
        case (cmd)
            CMD_ALLOC: begin
                if (per_group != 0) begin
                    groups = (total + per_group - 1) / per_group;
                    for (g = 0; g < groups && !found; g++) begin
                        if (g >= MAX_GROUPS_DEF || group_free[g] == 0) continue;
                        start = g * per_group;
                        lim   = per_group;
                        // last group only holds what remains of the total
                        if (g == groups - 1 && total > start) lim = total - start;
                        for (k = 0; k < lim && !found; k++) begin
                            idx = start + k;
                            num = idx + 32'(cfg_base);
                            if (num < 32'(cfg_first)) continue;
                            if (!cfg_base && num >= total) break;
                            if (idx < MAP_BITS_DEF &&
                                !used_map[idx / LOAD_WORD_BITS_DEF][idx % LOAD_WORD_BITS_DEF])
                            begin
                                used_map[idx / LOAD_WORD_BITS_DEF][idx % LOAD_WORD_BITS_DEF] = 1'b1;
                                if (total_free != 0) total_free--;
                                if (group_free[g] != 0) group_free[g]--;
                                grant.number = num[CNT_W-1:0];
                                grant.group  = g[OGRP_W-1:0];
                                found = 1;
                            end
                        end
                    end
                end
                grant.status = found ? STATUS_DONE : STATUS_NO_FREE;
            end
            CMD_LOAD_WORD: begin
                if (slot < MAP_WORDS) used_map[slot] = value[LOAD_WORD_BITS_DEF-1:0];
            end
            CMD_LOAD_GROUP: begin
                if (slot < MAX_GROUPS_DEF) group_free[slot] = value[CNT_W-1:0];
            end
            default: begin
                total_free = value[CNT_W-1:0];
            end
        endcase
        return grant;
    endfunction

    always @(posedge i_clk) begin
        t_grant want;
        t_grant got;
        if (!i_rst_n) begin
            for (int i = 0; i < MAP_WORDS; i++) used_map[i] = '0;
            for (int i = 0; i < MAX_GROUPS_DEF; i++) group_free[i] = '0;
            total_free    = '0;
            cfg_per_group = CNT_W'(4096);
            cfg_total     = CNT_W'(4096);
            cfg_first     = '0;
            cfg_base      = 1'b0;
            grants_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg'(i_paddr[3:2]))
                    REG_ITEMS_PER_GROUP: cfg_per_group = i_pwdata[CNT_W-1:0];
                    REG_TOTAL_ITEMS:     cfg_total     = i_pwdata[CNT_W-1:0];
                    REG_FIRST_USABLE:    cfg_first     = i_pwdata[CNT_W-1:0];
                    default:             cfg_base      = i_pwdata[0];
                endcase
            end
            if (i_res_tvalid && i_res_tready) begin
                got.status = i_res_tuser;
                got.number = i_res_tdata[CNT_W-1:0];
                got.group  = i_res_tdata[CNT_W +: OGRP_W];
                if (grants_due.size() == 0) begin
                    report_mismatch($sformatf("result transfer with nothing outstanding: %p", got));
                end else begin
                    want = grants_due.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  got.status, want.status));
                    if (got.number !== want.number)
                        report_mismatch($sformatf("allocated_number got %0d expected %0d",
                                                  got.number, want.number));
                    if (got.group !== want.group)
                        report_mismatch($sformatf("allocated_group got %0d expected %0d",
                                                  got.group, want.group));
                end
            end
            if (i_cmd_tvalid && i_cmd_tready) begin
                grants_due.push_back(grant_for_command(t_cmd'(i_cmd_tuser),
                                                       i_cmd_tdata[SLOT_W-1:0],
                                                       i_cmd_tdata[SLOT_W +: VALUE_W]));
            end
        end
        pending_cnt = grants_due.size();
    end

endmodule

/* bench/tb_grouped_bitmap_allocator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_grouped_bitmap_allocator
// Drives the allocator through directed corner cases and randomized phases
// of loads and allocations under several settings, with random idle cycles
// on both sides, a long result stall and drain pauses; the checker module
// predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_grouped_bitmap_allocator;
    import gba_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 150;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_ITEMS   = 160;
    localparam int HOLD_CYCLES   = 400;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [39:0]         s_axis_tdata;
    logic [CMD_W-1:0]    s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [15:0]         m_axis_tdata;
    logic                m_axis_tuser;

    int   fail_count;
    int   pending;
    int   idle_cycles = 0;
    logic steady   = 1'b0;
    logic hold_req = 1'b0;
    int   hold_left = 0;
    bit   hold_done = 0;

    grouped_bitmap_allocator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    grouped_bitmap_allocator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .i_cmd_tvalid (s_axis_tvalid),
        .i_cmd_tready (s_axis_tready),
        .i_cmd_tdata  (s_axis_tdata),
        .i_cmd_tuser  (s_axis_tuser),
        .i_res_tvalid (m_axis_tvalid),
        .i_res_tready (m_axis_tready),
        .i_res_tdata  (m_axis_tdata),
        .i_res_tuser  (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // result side: random back-pressure, one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("FAIL grouped_bitmap_allocator");
            $finish;
        end
    end

    task automatic send_cmd(input t_cmd cmd, input logic [SLOT_W-1:0] slot,
                            input logic [VALUE_W-1:0] value);
        while (!steady && $urandom_range(0, 99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, value, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // sender stops until every result is back, then lets the block settle
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg r, input logic [DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input int unsigned per_group, input int unsigned total,
                              input int unsigned first, input bit base);
        drain();
        write_reg(REG_ITEMS_PER_GROUP, per_group);
        write_reg(REG_TOTAL_ITEMS, total);
        write_reg(REG_FIRST_USABLE, first);
        write_reg(REG_NUMBER_BASE, DATA_W'(base));
    endtask

    task automatic send_random_cmd;
        int unsigned         r;
        logic [SLOT_W-1:0]   slot;
        logic [VALUE_W-1:0]  value;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            send_cmd(CMD_ALLOC, SLOT_W'($urandom), $urandom);
        end else if (r < 75) begin
            slot = ($urandom_range(0, 1) == 0) ? SLOT_W'($urandom_range(0, 15))
                                                : SLOT_W'($urandom);
            case ($urandom_range(0, 3))
                0:       value = '1;
                1:       value = $urandom;
                2:       value = $urandom | $urandom;
                default: value = ~(32'h1 << $urandom_range(0, 31));
            endcase
            send_cmd(CMD_LOAD_WORD, slot, value);
        end else if (r < 92) begin
            // some loads hit groups beyond the count store
            slot = ($urandom_range(0, 7) == 0) ? SLOT_W'($urandom_range(8, 127))
                                                : SLOT_W'($urandom_range(0, 7));
            case ($urandom_range(0, 7))
                0:       value = $urandom;
                1:       value = '0;
                default: value = $urandom_range(1, 300);
            endcase
            send_cmd(CMD_LOAD_GROUP, slot, value);
        end else begin
            send_cmd(CMD_LOAD_TOTAL, SLOT_W'($urandom), $urandom);
        end
    endtask

    initial begin
        int unsigned per_group, total, first;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_ALLOC;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: one group of 4096
        send_cmd(CMD_ALLOC, '0, '0);
        send_cmd(CMD_LOAD_GROUP, 7'd0, 32'hFFFF_E005);
        send_cmd(CMD_LOAD_GROUP, 7'd8, 32'd7);
        send_cmd(CMD_LOAD_GROUP, 7'd127, 32'd9);
        send_cmd(CMD_LOAD_TOTAL, 7'd127, 32'hFFFF_FFFF);
        send_cmd(CMD_LOAD_WORD, 7'd0, 32'hFFFF_FFFF);
        send_cmd(CMD_LOAD_WORD, 7'd1, 32'hFFFF_FFFE);
        send_cmd(CMD_ALLOC, 7'h7F, 32'hFFFF_FFFF);
        send_cmd(CMD_ALLOC, '0, '0);
        send_cmd(CMD_LOAD_WORD, 7'd127, 32'h7FFF_FFFF);
        send_cmd(CMD_ALLOC, '0, '0);

        // zero items per group, then zero total
        set_config(0, 4096, 0, 1'b0);
        send_cmd(CMD_ALLOC, '0, '0);
        set_config(1, 0, 0, 1'b0);
        send_cmd(CMD_ALLOC, '0, '0);

        // one item per group: only the first groups have counts
        set_config(1, 4096, 0, 1'b1);
        send_cmd(CMD_LOAD_WORD, 7'd0, 32'h0000_0001);
        send_cmd(CMD_LOAD_GROUP, 7'd7, 32'd1);
        send_cmd(CMD_ALLOC, '0, '0);
        send_cmd(CMD_ALLOC, '0, '0);

        // every number reserved
        set_config(4096, 4096, 4097, 1'b1);
        send_cmd(CMD_ALLOC, '0, '0);

        // base 0 scan ends at the total, base 1 reaches one number further
        set_config(4096, 40, 0, 1'b0);
        send_cmd(CMD_LOAD_GROUP, 7'd0, 32'd20);
        send_cmd(CMD_LOAD_WORD, 7'd0, 32'hFFFF_FFFF);
        send_cmd(CMD_LOAD_WORD, 7'd1, 32'hFFFF_007F);
        send_cmd(CMD_ALLOC, '0, '0);
        send_cmd(CMD_ALLOC, '0, '0);
        set_config(4096, 40, 0, 1'b1);
        send_cmd(CMD_ALLOC, '0, '0);

        for (int p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(0, 4))
                0:       per_group = 1;
                1:       per_group = 4096;
                2:       per_group = $urandom_range(1, 64);
                3:       per_group = $urandom_range(65, 4096);
                default: per_group = 512;
            endcase
            case ($urandom_range(0, 7))
                0:       total = 0;
                1, 2:    total = 4096;
                default: total = $urandom_range(1, 4096);
            endcase
            case ($urandom_range(0, 7))
                0:       first = $urandom_range(0, 4097);
                1, 2, 3: first = 0;
                default: first = $urandom_range(0, 600);
            endcase
            if (p == 0) begin
                per_group = 512;
                total     = 4096;
                first     = 0;
            end
            set_config(per_group, total, first, 1'($urandom_range(0, 1)));
            steady <= (p == 1);
            if (p == 2) hold_req <= 1'b1;
            // well-formed start: counts for every group, the total, a few map words
            for (int g = 0; g < MAX_GROUPS_DEF; g++) begin
                send_cmd(CMD_LOAD_GROUP, SLOT_W'(g), $urandom_range(1, 600));
            end
            send_cmd(CMD_LOAD_TOTAL, '0, $urandom_range(1, 4096));
            for (int w = 0; w < 4; w++) begin
                send_cmd(CMD_LOAD_WORD, SLOT_W'($urandom_range(0, 15)), $urandom);
            end
            for (int i = 0; i < PHASE_ITEMS - 13; i++) send_random_cmd();
        end
        steady <= 1'b0;

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("PASS grouped_bitmap_allocator");
        end else begin
            $display("FAIL grouped_bitmap_allocator");
        end
        $finish;
    end

endmodule
